// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the flow rate limiter; included by pfrl_ctrl.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/pfrl_pkg.sv -----
// Package for the per-flow packet rate limiter: widths, codes, word types.
// Used by pfrl_ctrl, pfrl_dp and the top level; depends on nothing.
`default_nettype none

package pfrl_pkg;

    localparam int FLOW_ENTRIES = 64;
    localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

    localparam int ADDR_W   = 32;
    localparam int TS_W     = 64;
    localparam int KEY_W    = 2 * ADDR_W;
    localparam int CNT_W    = 32;
    localparam int TO_W     = 40;
    localparam int RATE_W   = 20;
    localparam int LIM_W    = RATE_W + 1;
    localparam int CFG_W    = 40;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = $clog2(CNT_W);

    // count * 1e9 fits in 62 bits; (limit + 1) * span fits in 85 bits.
    localparam int PROD_A_W = 62;
    localparam int PROD_B_W = TS_W + LIM_W;

    localparam logic [63:0] NS_PER_SEC    = 64'd1000000000;
    localparam logic [TO_W-1:0]   IDLE_TO_RST  = TO_W'(64'd2000000000);
    localparam logic [TO_W-1:0]   MIN_WIN_RST  = TO_W'(64'd1000000000);
    localparam logic [RATE_W-1:0] RATE_LIM_RST = RATE_W'(500);

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT   = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_ABORT = 2'd0,
        VERDICT_DROP  = 2'd1,
        VERDICT_PASS  = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [TS_W-1:0]   now_ns;
        logic              header_complete;
    } t_in_word;

    typedef struct packed {
        t_verdict verdict;
        logic     flow_untracked;
    } t_out_word;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  start;
        logic [TS_W-1:0]  last;
        logic [CNT_W-1:0] count;
    } t_flow_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EVAL,
        ST_SPAN,
        ST_MULT,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic search_run;
        logic eval;
        logic span;
        logic mult_step;
        logic write;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_hdr;
        logic search_done;
        logic mult_last;
        logic out_free;
    } t_ctrl_stat;

endpackage

`default_nettype wire

// ----- hdl/pfrl_dp.sv -----
// Datapath of the flow rate limiter: config registers, flow table memory,
// search, shift-add rate multiply and result register. Depends on pfrl_pkg.
`default_nettype none

module pfrl_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire  [pfrl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [pfrl_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  pfrl_pkg::t_in_word                   i_in_word,
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output pfrl_pkg::t_out_word                  o_out_word,
    input  pfrl_pkg::t_ctrl_cmd                  i_cmd,
    output pfrl_pkg::t_ctrl_stat                 o_stat
);

    localparam logic [pfrl_pkg::IDX_W-1:0] LAST_IDX =
        pfrl_pkg::IDX_W'(pfrl_pkg::FLOW_ENTRIES - 1);

    logic [pfrl_pkg::TO_W-1:0]   r_idle_to;
    logic [pfrl_pkg::TO_W-1:0]   r_min_win;
    logic [pfrl_pkg::RATE_W-1:0] r_rate_lim;

    pfrl_pkg::t_in_word    r_in;
    pfrl_pkg::t_flow_entry r_mem [pfrl_pkg::FLOW_ENTRIES];
    pfrl_pkg::t_flow_entry r_rd;
    logic [pfrl_pkg::FLOW_ENTRIES-1:0] r_valid;

    logic [pfrl_pkg::IDX_W-1:0] r_scan_addr;
    logic [pfrl_pkg::IDX_W-1:0] r_cmp_idx;
    logic                       r_issue_done;
    logic                       r_cmp_vld;
    logic                       r_hit;
    logic [pfrl_pkg::IDX_W-1:0] r_hit_idx;
    logic                       r_free_ok;
    logic [pfrl_pkg::IDX_W-1:0] r_free_idx;
    logic [pfrl_pkg::TS_W-1:0]  r_e_start;
    logic [pfrl_pkg::TS_W-1:0]  r_e_last;
    logic [pfrl_pkg::CNT_W-1:0] r_e_cnt;

    logic [pfrl_pkg::TS_W-1:0]  r_start;
    logic [pfrl_pkg::CNT_W-1:0] r_cnt;
    logic [pfrl_pkg::TS_W-1:0]  r_span;
    logic                       r_over;
    logic                       r_drop;

    logic [pfrl_pkg::PROD_A_W-1:0] r_ma;
    logic [pfrl_pkg::PROD_A_W-1:0] r_acc_a;
    logic [pfrl_pkg::CNT_W-1:0]    r_mc;
    logic [pfrl_pkg::PROD_B_W-1:0] r_mb;
    logic [pfrl_pkg::PROD_B_W-1:0] r_acc_b;
    logic [pfrl_pkg::LIM_W-1:0]    r_ml;
    logic [pfrl_pkg::STEP_W-1:0]   r_step;

    logic                          r_out_valid;
    pfrl_pkg::t_out_word           r_out_word;

    logic                       issue;
    logic [pfrl_pkg::KEY_W-1:0] in_key;
    logic [pfrl_pkg::TS_W-1:0]  idle_gap;
    logic                       idle_exp;
    logic [pfrl_pkg::CNT_W-1:0] base_cnt;
    logic [pfrl_pkg::IDX_W-1:0] wr_idx;
    pfrl_pkg::t_flow_entry      wr_entry;

    assign issue    = i_cmd.search_run && !r_issue_done;
    assign in_key   = {r_in.src_addr, r_in.dst_addr};
    assign idle_gap = r_in.now_ns - r_e_last;
    assign idle_exp = idle_gap > {{(pfrl_pkg::TS_W - pfrl_pkg::TO_W){1'b0}}, r_idle_to};
    assign base_cnt = idle_exp ? '0 : r_e_cnt;
    assign wr_idx   = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        wr_entry.key   = in_key;
        wr_entry.start = r_start;
        wr_entry.last  = r_in.now_ns;
        wr_entry.count = r_cnt;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_to  <= pfrl_pkg::IDLE_TO_RST;
            r_min_win  <= pfrl_pkg::MIN_WIN_RST;
            r_rate_lim <= pfrl_pkg::RATE_LIM_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pfrl_pkg::CFG_IDLE_TIMEOUT: r_idle_to  <= i_cfg_wdata;
                pfrl_pkg::CFG_MIN_WINDOW:   r_min_win  <= i_cfg_wdata;
                pfrl_pkg::CFG_RATE_LIMIT:   r_rate_lim <= i_cfg_wdata[pfrl_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (r_hit || r_free_ok)) begin
            r_mem[wr_idx] <= wr_entry;
        end
        if (issue) begin
            r_rd <= r_mem[r_scan_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write && (r_hit || r_free_ok)) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // Capture of the input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
    end

    // Linear search: addresses go out one per cycle, and each compare works on the registered read of its address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr  <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_ok    <= 1'b0;
        end else if (i_cmd.load) begin
            r_scan_addr  <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_ok    <= 1'b0;
        end else begin
            r_cmp_vld <= issue;
            if (issue) begin
                r_cmp_idx <= r_scan_addr;
                if (r_scan_addr == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                end
            end
            if (r_cmp_vld) begin
                if (r_valid[r_cmp_idx]) begin
                    if (!r_hit && (r_rd.key == in_key)) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                        r_e_start <= r_rd.start;
                        r_e_last  <= r_rd.last;
                        r_e_cnt   <= r_rd.count;
                    end
                end else if (!r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
    end

    // Window update, span, the shift-add products and the drop decision.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            if (r_hit) begin
                r_start <= idle_exp ? r_in.now_ns : r_e_start;
                r_cnt   <= (&base_cnt) ? base_cnt : base_cnt + 1'b1;
            end else begin
                r_start <= r_in.now_ns;
                r_cnt   <= pfrl_pkg::CNT_W'(1);
            end
        end
        if (i_cmd.span) begin
            r_span  <= r_in.now_ns - r_start;
            r_mb    <= {{pfrl_pkg::LIM_W{1'b0}}, r_in.now_ns - r_start};
            r_ml    <= {1'b0, r_rate_lim} + 1'b1;
            r_ma    <= pfrl_pkg::PROD_A_W'(pfrl_pkg::NS_PER_SEC);
            r_mc    <= r_cnt;
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_step  <= '0;
        end
        if (i_cmd.mult_step) begin
            if (r_mc[0]) begin
                r_acc_a <= r_acc_a + r_ma;
            end
            if (r_ml[0]) begin
                r_acc_b <= r_acc_b + r_mb;
            end
            r_ma   <= r_ma << 1;
            r_mc   <= r_mc >> 1;
            r_mb   <= r_mb << 1;
            r_ml   <= r_ml >> 1;
            r_step <= r_step + 1'b1;
            r_over <= r_span > {{(pfrl_pkg::TS_W - pfrl_pkg::TO_W){1'b0}}, r_min_win};
        end
        // floor(count*1e9 / span) > limit holds exactly when
        // count*1e9 >= (limit + 1) * span.
        if (i_cmd.write) begin
            r_drop <= r_over &&
                ({{(pfrl_pkg::PROD_B_W - pfrl_pkg::PROD_A_W){1'b0}}, r_acc_a} >= r_acc_b);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (!r_in.header_complete) begin
                r_out_word.verdict        <= pfrl_pkg::VERDICT_ABORT;
                r_out_word.flow_untracked <= 1'b0;
            end else begin
                r_out_word.verdict <= r_drop ? pfrl_pkg::VERDICT_DROP
                                             : pfrl_pkg::VERDICT_PASS;
                r_out_word.flow_untracked <= !r_hit && !r_free_ok;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        o_stat.in_hdr      = i_in_word.header_complete;
        o_stat.search_done = r_cmp_vld && (r_cmp_idx == LAST_IDX);
        o_stat.mult_last   = r_step == pfrl_pkg::STEP_W'(pfrl_pkg::CNT_W - 1);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

// ----- hdl/pfrl_ctrl.sv -----
// Control state machine of the flow rate limiter: sequences search,
// evaluation, multiply, write-back and result hand-off. Depends on pfrl_pkg.
`default_nettype none
`include "assert_macros.svh"

module pfrl_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  pfrl_pkg::t_ctrl_stat  i_stat,
    output pfrl_pkg::t_ctrl_cmd   o_cmd
);

    pfrl_pkg::t_state r_state;
    pfrl_pkg::t_state n_state;
    logic             accept;

    assign accept = i_in_valid && (r_state == pfrl_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfrl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfrl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = i_stat.in_hdr ? pfrl_pkg::ST_SEARCH : pfrl_pkg::ST_DONE;
                end
            end
            pfrl_pkg::ST_SEARCH: begin
                if (i_stat.search_done) begin
                    n_state = pfrl_pkg::ST_EVAL;
                end
            end
            pfrl_pkg::ST_EVAL:  n_state = pfrl_pkg::ST_SPAN;
            pfrl_pkg::ST_SPAN:  n_state = pfrl_pkg::ST_MULT;
            pfrl_pkg::ST_MULT: begin
                if (i_stat.mult_last) begin
                    n_state = pfrl_pkg::ST_WRITE;
                end
            end
            pfrl_pkg::ST_WRITE: n_state = pfrl_pkg::ST_DONE;
            pfrl_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = pfrl_pkg::ST_IDLE;
                end
            end
            default: n_state = pfrl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = r_state == pfrl_pkg::ST_IDLE;
        o_cmd.load       = accept;
        o_cmd.search_run = r_state == pfrl_pkg::ST_SEARCH;
        o_cmd.eval       = r_state == pfrl_pkg::ST_EVAL;
        o_cmd.span       = r_state == pfrl_pkg::ST_SPAN;
        o_cmd.mult_step  = r_state == pfrl_pkg::ST_MULT;
        o_cmd.write      = r_state == pfrl_pkg::ST_WRITE;
        o_cmd.finish     = (r_state == pfrl_pkg::ST_DONE) && i_stat.out_free;
    end

    `ASSERT_CLK(a_search_after_accept, i_clk, i_rst_n, ((r_state == pfrl_pkg::ST_SEARCH) && ($past(r_state) == pfrl_pkg::ST_IDLE)) |-> $past(accept), "search entered without an accepted word")
    `ASSERT_CLK(a_write_after_mult, i_clk, i_rst_n, (r_state == pfrl_pkg::ST_WRITE) |-> ($past(r_state) == pfrl_pkg::ST_MULT), "write-back without a finished multiply")
    `ASSERT_NEVER(a_search_done_stray, i_clk, i_rst_n, i_stat.search_done && (r_state != pfrl_pkg::ST_SEARCH), "search completion outside the search phase")

endmodule

`default_nettype wire

// ----- hdl/per_flow_packet_rate_limiter.sv -----
// Top level of the per-flow packet rate limiter.
// Instantiates pfrl_ctrl and pfrl_dp; types and constants come from pfrl_pkg.
`default_nettype none

// The limiter takes one packet descriptor word at a time and returns one
// verdict word per input word, in order. A word whose header_complete bit is
// clear goes straight to the done state, has its result loaded there once the
// output register is free, and leaves the flow table untouched. Any other
// word walks the whole flow table, one entry per cycle through a single
// registered memory read port, then updates the window in the evaluation
// state, forms its span in the span state, runs a shift-add unit that forms
// count times 1e9 and (limit plus one) times span side by side, writes back
// its table entry if it has one, and loads the result once the output
// register is free. The next word is accepted as soon as the result has been
// moved into the output register, even if the consumer has not yet taken it.
// New flows take the lowest free entry; when the table is full the packet is
// judged as a fresh flow, passes, and is flagged untracked. Configuration
// registers must be written only while the block is idle; reset restores
// their defaults and marks every table entry free, with no clearing pass
// needed.
module per_flow_packet_rate_limiter (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [pfrl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [pfrl_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  pfrl_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output pfrl_pkg::t_out_word              o_out_word
);

    pfrl_pkg::t_ctrl_cmd  cmd;
    pfrl_pkg::t_ctrl_stat stat;

    // The controller sequences the phases and owns the input handshake.
    pfrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the table, the arithmetic and the result register.
    pfrl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire
